// ===== design/lpg_pkg.sv =====
package lpg_pkg;

  // coordinate width of the endpoints and of the generated points
  localparam int unsigned COORD_BITS = 12;
  // step counters hold N = |dx| + |dy|, which needs one more bit
  localparam int unsigned STEP_BITS  = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  // operation codes of the input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic   op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } lpg_in_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   last;
  } lpg_out_t;

endpackage

// ===== design/line_point_generator_unit.sv =====
// Line point generator. A load word (op = OP_LOAD) latches two endpoints and
// produces nothing; every following tick word (op = OP_TICK) produces the next
// of the N + 1 points of the line, N = |dx| + |dy|, the final one flagged with
// last. Each coordinate is start + k*d/N rounded half up, kept exact with a
// quotient/remainder accumulator per axis, so the last point is the end point.
// Ticks while no line is active produce nothing; a load while a line is
// active abandons it. One word is taken per clock: every point costs one
// add-and-compare per axis between the accumulator registers and the output
// register, and a new word enters in the same cycle that a waiting point is
// taken; while a point waits and out_ready_i is low the input stalls.
// out_valid_o rises in the cycle after a tick is accepted.
module line_point_generator_unit import lpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lpg_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lpg_out_t out_data_o
);

  // rounded coordinate of point k from base, sign, quotient and remainder
  function automatic coord_t coord_of(coord_t base, logic neg, coord_t q,
                                      step_t r, step_t n);
    logic [STEP_BITS:0] r2;
    logic [STEP_BITS:0] n_ext;
    logic               up;
    r2    = {r, 1'b0};
    n_ext = {1'b0, n};
    if (neg) begin
      up = (r2 > n_ext);
      coord_of = base - q - coord_t'(up);
    end else begin
      up = (r != '0) && (r2 >= n_ext);
      coord_of = base + q + coord_t'(up);
    end
  endfunction

  // line state
  logic     busy_q, busy_d;
  coord_t   base_x_q, base_x_d, base_y_q, base_y_d;
  coord_t   span_x_q, span_x_d, span_y_q, span_y_d;
  logic     neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  coord_t   quot_x_q, quot_x_d, quot_y_q, quot_y_d;
  step_t    rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  step_t    step_index_q, step_index_d;
  step_t    step_total_q, step_total_d;

  // output register
  logic     out_valid_q, out_valid_d;
  lpg_out_t out_data_q, out_data_d;

  logic     accept;
  logic     emit;
  logic     is_last;

  // remainder sums, one bit wider than the remainder
  logic [STEP_BITS:0] sum_x, sum_y;
  logic [STEP_BITS:0] sub_x, sub_y;
  logic               wrap_x, wrap_y;

  // a waiting point does not block a new word if it leaves this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && (in_data_i.op == OP_TICK) && busy_q;
  assign is_last    = (step_index_q == step_total_q);

  // per-axis accumulator step: add the span, take off at most one N
  assign sum_x  = {1'b0, rem_x_q} + {2'b00, span_x_q};
  assign sum_y  = {1'b0, rem_y_q} + {2'b00, span_y_q};
  assign wrap_x = (sum_x >= {1'b0, step_total_q});
  assign wrap_y = (sum_y >= {1'b0, step_total_q});
  assign sub_x  = sum_x - {1'b0, step_total_q};
  assign sub_y  = sum_y - {1'b0, step_total_q};

  always_comb begin
    busy_d       = busy_q;
    base_x_d     = base_x_q;
    base_y_d     = base_y_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    quot_x_d     = quot_x_q;
    quot_y_d     = quot_y_q;
    rem_x_d      = rem_x_q;
    rem_y_d      = rem_y_q;
    step_index_d = step_index_q;
    step_total_d = step_total_q;

    if (accept && (in_data_i.op == OP_LOAD)) begin
      // new line: latch start point, absolute spans and directions
      base_x_d     = in_data_i.x_start;
      base_y_d     = in_data_i.y_start;
      neg_x_d      = (in_data_i.x_end < in_data_i.x_start);
      neg_y_d      = (in_data_i.y_end < in_data_i.y_start);
      span_x_d     = neg_x_d ? (in_data_i.x_start - in_data_i.x_end)
                             : (in_data_i.x_end - in_data_i.x_start);
      span_y_d     = neg_y_d ? (in_data_i.y_start - in_data_i.y_end)
                             : (in_data_i.y_end - in_data_i.y_start);
      quot_x_d     = '0;
      quot_y_d     = '0;
      rem_x_d      = '0;
      rem_y_d      = '0;
      step_index_d = '0;
      step_total_d = {1'b0, span_x_d} + {1'b0, span_y_d};
      busy_d       = 1'b1;
    end else if (emit) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        step_index_d = step_index_q + step_t'(1);
        rem_x_d      = wrap_x ? sub_x[STEP_BITS-1:0] : sum_x[STEP_BITS-1:0];
        rem_y_d      = wrap_y ? sub_y[STEP_BITS-1:0] : sum_y[STEP_BITS-1:0];
        quot_x_d     = quot_x_q + coord_t'(wrap_x);
        quot_y_d     = quot_y_q + coord_t'(wrap_y);
      end
    end
  end

  // point k comes from the accumulators as they stand before the step
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d     = 1'b1;
      out_data_d.px   = coord_of(base_x_q, neg_x_q, quot_x_q, rem_x_q, step_total_q);
      out_data_d.py   = coord_of(base_y_q, neg_y_q, quot_y_q, rem_y_q, step_total_q);
      out_data_d.last = is_last;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath state, meaningful only while busy or valid
  always_ff @(posedge clk_i) begin
    base_x_q     <= base_x_d;
    base_y_q     <= base_y_d;
    span_x_q     <= span_x_d;
    span_y_q     <= span_y_d;
    neg_x_q      <= neg_x_d;
    neg_y_q      <= neg_y_d;
    quot_x_q     <= quot_x_d;
    quot_y_q     <= quot_y_d;
    rem_x_q      <= rem_x_d;
    rem_y_q      <= rem_y_d;
    step_index_q <= step_index_d;
    step_total_q <= step_total_d;
    out_data_q   <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import lpg_pkg::*;

  // one stimulus word plus a flag asking the sender to wait for an empty pipe
  typedef struct {
    lpg_in_t word;
    bit      drain;
  } queued_word_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  lpg_in_t  in_data     = '0;
  logic     out_ready   = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  lpg_out_t out_data_o;

  // handshakes seen at the last rising edge
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;

  queued_word_t words_pending[$];
  lpg_out_t     points_due[$];
  int unsigned  words_built    = 0;
  int unsigned  points_checked = 0;
  int unsigned  mismatches     = 0;

  // line state mirrored from the accepted words
  bit     line_busy = 1'b0;
  coord_t base_x = '0, base_y = '0;
  coord_t span_x = '0, span_y = '0;
  bit     neg_x = 1'b0, neg_y = 1'b0;
  coord_t quot_x = '0, quot_y = '0;
  step_t  rem_x = '0, rem_y = '0;
  step_t  step_index = '0, step_total = '0;

  line_point_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // coordinate of point k on one axis: base +- k*span/N rounded half up
  function automatic coord_t axis_point(coord_t base, bit neg, coord_t q, step_t r,
                                        step_t n);
    logic [STEP_BITS:0] twice_r;
    logic               up;
    twice_r = {r, 1'b0};
    if (neg) begin
      up = (twice_r > {1'b0, n});
      return base - q - coord_t'(up);
    end
    up = (r != '0) && (twice_r >= {1'b0, n});
    return base + q + coord_t'(up);
  endfunction

  // move the quotient/remainder pair on by span/N; the sum needs a spare bit
  task automatic axis_step(inout coord_t q, inout step_t r, input coord_t span,
                           input step_t n);
    logic [STEP_BITS:0] sum;
    sum = {1'b0, r} + {2'b00, span};
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
      q   = q + coord_t'(1);
    end
    r = sum[STEP_BITS-1:0];
  endtask

  function automatic coord_t span_of(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // pick a coordinate within reach of c, folded back if it would leave the range
  function automatic coord_t nudge(coord_t c, int reach);
    int d;
    int t;
    d = int'($urandom_range(0, 2 * reach)) - reach;
    t = int'(c) + d;
    if (t < 0 || t > 4095) t = int'(c) - d;
    return coord_t'(t);
  endfunction

  // a random base, now and then hugging one edge of the range
  function automatic coord_t pick_base();
    case ($urandom_range(0, 7))
      0: return coord_t'($urandom_range(0, 3));
      1: return coord_t'($urandom_range(4092, 4095));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_word(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                          bit drain);
    queued_word_t qw;
    qw.word.op      = op;
    qw.word.x_start = xs;
    qw.word.y_start = ys;
    qw.word.x_end   = xe;
    qw.word.y_end   = ye;
    qw.drain        = drain;
    words_pending.push_back(qw);
    words_built++;
  endtask

  // tick words carry junk in the coordinate fields, which must be ignored
  task automatic add_ticks(int unsigned count);
    repeat (count) add_word(OP_TICK, coord_t'($urandom), coord_t'($urandom),
                            coord_t'($urandom), coord_t'($urandom), 1'b0);
  endtask

  task automatic add_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                          int unsigned ticks, bit drain);
    add_word(OP_LOAD, xs, ys, xe, ye, drain);
    add_ticks(ticks);
  endtask

  // stimulus build, reset and end of run
  initial begin
    coord_t      xs, ys, xe, ye;
    int unsigned pick, reach;
    bit          drain;

    // directed: idle tick, a zero length line at one corner, short lines at others, both signs,
    // rounding ties, extreme endpoints, loads that drop a running line
    add_ticks(1);
    add_line(12'd0, 12'd0, 12'd0, 12'd0, 2, 1'b0);
    add_line(12'd4095, 12'd4095, 12'd4093, 12'd4094, 4, 1'b0);
    add_line(12'd0, 12'd4095, 12'd2, 12'd4094, 4, 1'b0);
    add_line(12'd0, 12'd0, 12'd4095, 12'd4095, 3, 1'b0);
    add_line(12'd4095, 12'd4095, 12'd0, 12'd0, 2, 1'b0);
    add_word(OP_LOAD, 12'd4095, 12'd0, 12'd0, 12'd4095, 1'b0);
    add_line(12'd2, 12'd2, 12'd1, 12'd3, 3, 1'b0);

    // random: mostly complete short lines with random placement
    drain = 1'b1;
    while (words_built < 1300) begin
      pick = $urandom_range(0, 99);
      xs   = pick_base();
      ys   = pick_base();
      if (pick < 72) begin
        reach = ($urandom_range(0, 3) == 0) ? 2 : 10;
        xe = nudge(xs, reach);
        ye = nudge(ys, reach);
        add_line(xs, ys, xe, ye, int'(span_of(xs, xe)) + int'(span_of(ys, ye)) + 1,
                 drain);
        // the odd trailing tick after the line is done
        if ($urandom_range(0, 3) == 0) add_ticks($urandom_range(1, 2));
      end else if (pick < 82) begin
        // far apart endpoints, cut short by whatever comes next
        add_line(xs, ys, pick_base(), pick_base(), $urandom_range(1, 40), drain);
      end else if (pick < 88) begin
        xe = nudge(xs, 60);
        ye = nudge(ys, 60);
        add_line(xs, ys, xe, ye, int'(span_of(xs, xe)) + int'(span_of(ys, ye)) + 1,
                 drain);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6))
          add_word($urandom_range(0, 1) ? OP_TICK : OP_LOAD, coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), drain);
      end else begin
        // back to back loads, only the second one counts
        add_word(OP_LOAD, xs, ys, pick_base(), pick_base(), drain);
        xe = nudge(xs, 8);
        ye = nudge(ys, 8);
        add_line(xs, ys, xe, ye, int'(span_of(xs, xe)) + int'(span_of(ys, ye)) + 1,
                 1'b0);
      end
      drain = ($urandom_range(0, 19) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (points_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (points_due.size() != 0) begin
      mismatches++;
      $display("%0d points never arrived", points_due.size());
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // limit on the whole run, many times the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // sender: one word at a time, random gap after each accepted word
  int unsigned send_gap = 0;
  bit          tx_calm  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_taken) in_valid = 1'b0;
      if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (words_pending.size() != 0 &&
                     (!words_pending[0].drain || points_due.size() == 0)) begin
          in_data  = words_pending[0].word;
          in_valid = 1'b1;
          void'(words_pending.pop_front());
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          send_gap = tx_calm ? 0 : $urandom_range(0, 10);
        end
      end
    end
  end

  // receiver: random stall per point plus a couple of long hold-offs
  int unsigned rx_wait      = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 100;
  bit          rx_calm      = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left == 0 && points_checked >= next_hold_at) begin
        hold_left    = 200;
        next_hold_at = next_hold_at + 600;
      end
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // monitor: check the point taken at this edge, then predict from the word taken
  always @(posedge clk_i) begin
    lpg_out_t got;
    lpg_out_t want;
    lpg_in_t  word;
    if (rst_ni) begin
      in_taken  = in_valid && in_ready_o;
      out_taken = out_valid_o && out_ready;

      if (out_taken) begin
        got = out_data_o;
        points_checked++;
        if (points_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected point px=%0d py=%0d last=%0b", got.px, got.py, got.last);
        end else begin
          want = points_due.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("point %0d: expected px=%0d py=%0d last=%0b, got px=%0d py=%0d last=%0b",
                       points_checked, want.px, want.py, want.last,
                       got.px, got.py, got.last);
          end
        end
      end

      if (in_taken) begin
        word = in_data;
        if (word.op == OP_LOAD) begin
          // a load always restarts, even in the middle of a line
          base_x     = word.x_start;
          base_y     = word.y_start;
          neg_x      = (word.x_end < word.x_start);
          neg_y      = (word.y_end < word.y_start);
          span_x     = span_of(word.x_start, word.x_end);
          span_y     = span_of(word.y_start, word.y_end);
          quot_x     = '0;
          quot_y     = '0;
          rem_x      = '0;
          rem_y      = '0;
          step_index = '0;
          step_total = {1'b0, span_x} + {1'b0, span_y};
          line_busy  = 1'b1;
        end else if (line_busy) begin
          want.px   = axis_point(base_x, neg_x, quot_x, rem_x, step_total);
          want.py   = axis_point(base_y, neg_y, quot_y, rem_y, step_total);
          want.last = (step_index == step_total);
          points_due.push_back(want);
          if (want.last) begin
            line_busy = 1'b0;
          end else begin
            step_index = step_index + step_t'(1);
            axis_step(quot_x, rem_x, span_x, step_total);
            axis_step(quot_y, rem_y, span_y, step_total);
          end
        end
      end
    end
  end

endmodule

// ===== sim.f =====
design/lpg_pkg.sv
design/line_point_generator_unit.sv
tb/testbench.sv
